[hdl/cdq_pkg.sv]
// Shared constants, codes and types of the circular double-ended queue.
`timescale 1ns / 1ps

package cdq_pkg;

    // Number of store entries with its index and capacity widths, and other widths.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = 4;
    localparam int CAP_W  = 5;
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    // Request codes.
    localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 2'd2;
    localparam logic [OP_W-1:0] OP_REM_REAR  = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

    // What the index controller decides for the request on offer.
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] addr;
        logic [ST_W-1:0]  status;
    } t_decision;

    // Handshake sequencer of the top level.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

endpackage

[hdl/cdq_req_if.sv]
// Request channel: valid, ready, opcode and value.
`timescale 1ns / 1ps

interface cdq_req_if;
    logic                       valid;
    logic                       ready;
    logic [cdq_pkg::OP_W-1:0]   opcode;
    logic signed [cdq_pkg::DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

[hdl/cdq_rsp_if.sv]
// Response channel: valid, ready, removed value and status.
`timescale 1ns / 1ps

interface cdq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [cdq_pkg::DATA_W-1:0] removed_value;
    logic [cdq_pkg::ST_W-1:0]          status;

    modport source (output valid, output removed_value, output status, input ready);
    modport sink   (input valid, input removed_value, input status, output ready);
endinterface

[hdl/cdq_store.sv]
// Element store: one-port synchronous memory with a registered read.
`timescale 1ns / 1ps

module cdq_store (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic                         i_rd_en,
    input  logic [cdq_pkg::IDX_W-1:0]    i_addr,
    input  logic [cdq_pkg::DATA_W-1:0]   i_wr_data,
    output logic [cdq_pkg::DATA_W-1:0]   o_rd_data
);

    logic [cdq_pkg::DATA_W-1:0] r_mem [cdq_pkg::DEPTH];
    logic [cdq_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/cdq_ctrl.sv]
// Index controller: capacity, front and rear indices, empty flag, request decode.
`timescale 1ns / 1ps

module cdq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                        i_accept,
    input  logic [cdq_pkg::OP_W-1:0]    i_opcode,
    output cdq_pkg::t_decision          o_dec
);

    logic [cdq_pkg::CAP_W-1:0] r_cap, n_cap;
    logic [cdq_pkg::IDX_W-1:0] r_front, n_front;
    logic [cdq_pkg::IDX_W-1:0] r_rear, n_rear;
    logic                      r_empty, n_empty;

    logic [cdq_pkg::CAP_W-1:0] cap_use;
    logic [cdq_pkg::CAP_W-1:0] front_inc, rear_inc;
    logic [cdq_pkg::IDX_W-1:0] cap_last;
    logic [cdq_pkg::IDX_W-1:0] front_next, front_prev, rear_next, rear_prev;
    logic                      full;
    logic                      single;
    cdq_pkg::t_decision        dec;

    // Capacity in use: zero acts as one, anything above the store depth saturates.
    always_comb begin
        if (r_cap == '0) begin
            cap_use = cdq_pkg::CAP_W'(1);
        end else if (r_cap > cdq_pkg::CAP_W'(cdq_pkg::DEPTH)) begin
            cap_use = cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
        end else begin
            cap_use = r_cap;
        end
    end

    assign cap_last   = cdq_pkg::IDX_W'(cap_use - cdq_pkg::CAP_W'(1));
    assign front_inc  = {1'b0, r_front} + cdq_pkg::CAP_W'(1);
    assign rear_inc   = {1'b0, r_rear} + cdq_pkg::CAP_W'(1);
    assign front_next = (front_inc >= cap_use) ? '0 : front_inc[cdq_pkg::IDX_W-1:0];
    assign rear_next  = (rear_inc >= cap_use) ? '0 : rear_inc[cdq_pkg::IDX_W-1:0];
    assign front_prev = (r_front == '0) ? cap_last : r_front - cdq_pkg::IDX_W'(1);
    assign rear_prev  = (r_rear == '0) ? cap_last : r_rear - cdq_pkg::IDX_W'(1);
    assign full       = !r_empty && (rear_next == r_front);
    assign single     = (r_front == r_rear);

    always_comb begin
        n_cap   = r_cap;
        n_front = r_front;
        n_rear  = r_rear;
        n_empty = r_empty;
        dec     = '{wr_en: 1'b0, rd_en: 1'b0, addr: '0, status: cdq_pkg::ST_DONE};

        unique case (i_opcode) inside
            cdq_pkg::OP_INS_FRONT, cdq_pkg::OP_INS_REAR: begin
                if (r_empty) begin
                    dec.wr_en = 1'b1;
                    dec.addr  = '0;
                    n_front   = '0;
                    n_rear    = '0;
                    n_empty   = 1'b0;
                end else if (full) begin
                    dec.status = cdq_pkg::ST_OVERFLOW;
                end else if (i_opcode == cdq_pkg::OP_INS_FRONT) begin
                    dec.wr_en = 1'b1;
                    dec.addr  = front_prev;
                    n_front   = front_prev;
                end else begin
                    dec.wr_en = 1'b1;
                    dec.addr  = rear_next;
                    n_rear    = rear_next;
                end
            end
            cdq_pkg::OP_REM_FRONT: begin
                if (r_empty) begin
                    dec.status = cdq_pkg::ST_EMPTY;
                end else begin
                    dec.rd_en = 1'b1;
                    dec.addr  = r_front;
                    if (single) begin
                        n_front = '0;
                        n_rear  = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_front = front_next;
                    end
                end
            end
            default: begin
                if (r_empty) begin
                    dec.status = cdq_pkg::ST_EMPTY;
                end else begin
                    dec.rd_en = 1'b1;
                    dec.addr  = r_rear;
                    if (single) begin
                        n_front = '0;
                        n_rear  = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_rear = rear_prev;
                    end
                end
            end
        endcase

        // Only an accepted request changes state or touches the store.
        if (!i_accept) begin
            n_front   = r_front;
            n_rear    = r_rear;
            n_empty   = r_empty;
            dec.wr_en = 1'b0;
            dec.rd_en = 1'b0;
        end

        // A capacity write also empties the queue.
        if (i_cfg_we) begin
            n_cap   = i_cfg_data;
            n_front = '0;
            n_rear  = '0;
            n_empty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= cdq_pkg::CAP_RESET;
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_cap   <= n_cap;
            r_front <= n_front;
            r_rear  <= n_rear;
            r_empty <= n_empty;
        end
    end

    assign o_dec = dec;

endmodule

[hdl/circular_deque.sv]
// Top level of the circular double-ended queue.
`timescale 1ns / 1ps

// The block is a double-ended queue of up to 16 signed 32-bit elements.
// Requests arrive on i_req (valid/ready): an opcode that inserts at the front
// or rear, or removes from the front or rear, and a value used by inserts.
// Each accepted request produces exactly one transaction on o_rsp carrying
// the removed value (zero unless a removal succeeded) and a status code.
// The capacity register is written through i_cfg_we and i_cfg_data; a write
// sets the wrap point of both indices and empties the queue.
// Inserts and refused requests are answered in the cycle after acceptance.
// A successful removal reads the element store and is answered from the
// store's read register through the output register. One request is in
// flight at a time, so a request is taken every cycle for inserts while the
// receiver keeps up, and none while a removal waits on the store. The
// response sits in an output register, so a new request is accepted in the
// same cycle that a waiting response is taken. When the receiver stalls,
// the response holds and no further request is accepted.
// Reset (synchronous, active low) empties the queue, sets the capacity to
// 16 and drops o_rsp.valid; store contents are not cleared.

module circular_deque (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_data,
    cdq_req_if.sink                     i_req,
    cdq_rsp_if.source                   o_rsp
);

    cdq_pkg::t_state    r_state, n_state;
    cdq_pkg::t_decision dec;

    logic                       r_out_valid, n_out_valid;
    logic [cdq_pkg::DATA_W-1:0] r_out_value, n_out_value;
    logic [cdq_pkg::ST_W-1:0]   r_out_status, n_out_status;
    logic [cdq_pkg::DATA_W-1:0] rd_data;
    logic                       req_ready;
    logic                       accept;

    // A request is taken only while no removal is waiting on the store and
    // the output register is empty or being emptied in this cycle.
    assign req_ready = (r_state == cdq_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept    = i_req.valid && req_ready;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_opcode   (i_req.opcode),
        .o_dec      (dec)
    );

    cdq_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (dec.wr_en),
        .i_rd_en   (dec.rd_en),
        .i_addr    (dec.addr),
        .i_wr_data (i_req.value),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid;

        // The response register frees up when its transaction completes.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                if (accept) begin
                    if (dec.rd_en) begin
                        // The store answers on the next cycle.
                        n_state = cdq_pkg::S_READ;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_value  = '0;
                        n_out_status = dec.status;
                    end
                end
            end
            cdq_pkg::S_READ: begin
                n_state      = cdq_pkg::S_IDLE;
                n_out_valid  = 1'b1;
                n_out_value  = rd_data;
                n_out_status = cdq_pkg::ST_DONE;
            end
            default: begin
                n_state = cdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign i_req.ready         = req_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.removed_value = r_out_value;
    assign o_rsp.status        = r_out_status;

endmodule

[hdl/cdq_checker.sv]
// Port-level checker of the circular double-ended queue and its bind.
`timescale 1ns / 1ps

module cdq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic [cdq_pkg::OP_W-1:0]    i_req_opcode,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [cdq_pkg::DATA_W-1:0]  i_rsp_value,
    input logic [cdq_pkg::ST_W-1:0]    i_rsp_status
);

    logic [cdq_pkg::OP_W-1:0] r_last_op;

    // Opcode of the most recent accepted request; the response shown belongs to it.
    always_ff @(posedge i_clk) begin
        if (i_req_valid && i_req_ready) begin
            r_last_op <= i_req_opcode;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_overflow_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == cdq_pkg::ST_OVERFLOW) |->
        (r_last_op == cdq_pkg::OP_INS_FRONT || r_last_op == cdq_pkg::OP_INS_REAR))
        else $error("overflow status for a removal");

    a_empty_on_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == cdq_pkg::ST_EMPTY) |->
        (r_last_op == cdq_pkg::OP_REM_FRONT || r_last_op == cdq_pkg::OP_REM_REAR))
        else $error("empty status for an insert");

    a_value_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != cdq_pkg::ST_DONE) |-> (i_rsp_value == '0))
        else $error("nonzero value on a refused request");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_status)))
        else $error("stalled response changed");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_opcode (i_req.opcode),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_value  (o_rsp.removed_value),
    .i_rsp_status (o_rsp.status)
);
